// ===== rtl/core/dvt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared widths, register codes, pipeline control type and helpers for the
// trimmed 2x2 depth volume block.
// ----------------------------------------------------------------------------
package dvt_pkg;

  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 13;
  localparam int BG_BITS        = 16;
  localparam int VOL_BITS       = 40;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_BITS       = 12;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  localparam logic [FW_BITS-1:0] WIDTH_RESET  = FW_BITS'(1024);
  localparam logic [FH_BITS-1:0] HEIGHT_RESET = FH_BITS'(1024);
  localparam logic [BG_BITS-1:0] BG_RESET     = '0;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACKGROUND_DEPTH = 2'd2;

  // Width of one per-pixel volume contribution.
  function automatic int contrib_bits(input int pixel_bits);
    int vb;
    vb = (pixel_bits > BG_BITS) ? pixel_bits : BG_BITS;
    return vb + 2;
  endfunction

  // Control that travels with a pixel down the pipe.
  typedef struct packed {
    logic valid;
    logic on_border;  // pixel belongs to no 2x2 block
    logic pair;       // pixel closes a 2x2 block
    logic last;       // last pixel of the frame
  } dvt_ctl_t;

endpackage

// ===== rtl/core/dvt_line_buffer.sv =====
// ----------------------------------------------------------------------------
// dvt_line_buffer
// Upper-row store split into even-column and odd-column banks, so that one
// read address yields both pixels above a 2x2 block. Read data registered.
// ----------------------------------------------------------------------------
module dvt_line_buffer #(
  parameter int PIXEL_BITS = dvt_pkg::DEF_PIXEL_BITS,
  parameter int HALF_DEPTH = dvt_pkg::DEF_MAX_WIDTH / 2,
  parameter int ADDR_BITS  = 9
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic                  wr_odd,
  input  logic [ADDR_BITS-1:0]  addr,
  input  logic [PIXEL_BITS-1:0] wr_data,
  input  logic                  rd_en,
  output logic [PIXEL_BITS-1:0] rd_even,
  output logic [PIXEL_BITS-1:0] rd_odd
);
  import dvt_pkg::*;

  logic [PIXEL_BITS-1:0] even_mem [HALF_DEPTH];
  logic [PIXEL_BITS-1:0] odd_mem  [HALF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_odd) begin
      even_mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_even <= even_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_odd) begin
      odd_mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_odd <= odd_mem[addr];
    end
  end

endmodule

// ===== rtl/core/dvt_trim_unit.sv =====
// ----------------------------------------------------------------------------
// dvt_trim_unit
// Trimmed-mean contribution of one pixel: border excess, or twice the middle
// pair of a 2x2 block above twice the background. Result registered.
// ----------------------------------------------------------------------------
module dvt_trim_unit #(
  parameter int PIXEL_BITS = dvt_pkg::DEF_PIXEL_BITS,
  parameter int CB         = dvt_pkg::contrib_bits(dvt_pkg::DEF_PIXEL_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  dvt_pkg::dvt_ctl_t            ctl_in,
  input  logic [PIXEL_BITS-1:0]        px,
  input  logic [PIXEL_BITS-1:0]        left,
  input  logic [PIXEL_BITS-1:0]        up_even,
  input  logic [PIXEL_BITS-1:0]        up_odd,
  input  logic [dvt_pkg::BG_BITS-1:0]  bg,
  output dvt_pkg::dvt_ctl_t            ctl_out,
  output logic [CB-1:0]                contrib
);
  import dvt_pkg::*;

  logic [CB-1:0] a, b, d, e, bg_x, mx, mn, mid, two_bg;
  logic [CB-1:0] pair_val, border_val, contrib_next;

  always_comb begin
    a    = CB'(up_even);
    b    = CB'(up_odd);
    d    = CB'(left);
    e    = CB'(px);
    bg_x = CB'(bg);

    mx = a;
    mn = a;
    if (b > mx) mx = b;
    if (d > mx) mx = d;
    if (e > mx) mx = e;
    if (b < mn) mn = b;
    if (d < mn) mn = d;
    if (e < mn) mn = e;

    mid    = a + b + d + e - mx - mn;
    two_bg = bg_x << 1;

    pair_val   = (mid > two_bg) ? ((mid - two_bg) << 1) : '0;
    border_val = (e > bg_x) ? (e - bg_x) : '0;

    priority if (ctl_in.on_border) begin
      contrib_next = border_val;
    end else if (ctl_in.pair) begin
      contrib_next = pair_val;
    end else begin
      contrib_next = '0;
    end
  end

  // Hold the stage while the pipe is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
    if (adv) begin
      contrib <= contrib_next;
    end
  end

endmodule

// ===== rtl/core/dvt_accum.sv =====
// ----------------------------------------------------------------------------
// dvt_accum
// Saturating frame volume accumulator and output result register.
// ----------------------------------------------------------------------------
module dvt_accum #(
  parameter int CB = dvt_pkg::contrib_bits(dvt_pkg::DEF_PIXEL_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  dvt_pkg::dvt_ctl_t             ctl,
  input  logic [CB-1:0]                 contrib,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dvt_pkg::VOL_BITS-1:0]  volume_total
);
  import dvt_pkg::*;

  logic [VOL_BITS-1:0] volume_sum;
  logic [VOL_BITS:0]   sum_wide;
  logic [VOL_BITS-1:0] sum_sat;

  always_comb begin
    sum_wide = {1'b0, volume_sum} + (VOL_BITS + 1)'(contrib);
    sum_sat  = sum_wide[VOL_BITS] ? {VOL_BITS{1'b1}} : sum_wide[VOL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv && ctl.valid) begin
        if (ctl.last) begin
          volume_sum <= '0;
          out_valid  <= 1'b1;
        end else begin
          volume_sum <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.valid && ctl.last) begin
      volume_total <= sum_sat;
    end
  end

endmodule

// ===== rtl/core/depth_volume_trimmed_2x2.sv =====
// ----------------------------------------------------------------------------
// depth_volume_trimmed_2x2
// Streaming depth volume over aligned 2x2 blocks with the extreme pixels
// trimmed; odd last column and odd last row add their plain excess.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock, tiny frames included. The input is held off
//   only while a frame end waits in the trim stage behind a volume beat that
//   the receiver has not yet taken; the whole pipe holds with it.
// Result path: the volume beat follows the last pixel's beat through the
//   line-store read, the trim stage and the accumulate into the result
//   register, and waits while the pipe is held.
// Reset (rst, synchronous): counters, left pixel, volume and all valid flags
//   clear; registers return to width 1024, height 1024, background 0. The line
//   store is not cleared, so reset does not wait on it.
// ----------------------------------------------------------------------------
module depth_volume_trimmed_2x2 #(
  parameter int MAX_WIDTH  = dvt_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = dvt_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PIXEL_BITS-1:0]             depth_pixel,
  // volume stream
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dvt_pkg::VOL_BITS-1:0]      volume_total,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dvt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [dvt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import dvt_pkg::*;

  // Column counter and line store geometry.
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int HALF_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_BITS  = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int WCLOG      = $clog2(MAX_WIDTH + 1);
  localparam int WCMP       = (FW_BITS > WCLOG) ? FW_BITS : WCLOG;
  localparam int CB         = contrib_bits(PIXEL_BITS);

  // Configuration registers.
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic [BG_BITS-1:0] background_depth;

  // Raster position and the previous pixel of the row.
  logic [COL_BITS-1:0]   column_count;
  logic [ROW_BITS-1:0]   row_count;
  logic [PIXEL_BITS-1:0] left_pixel;

  // Stage one: accepted pixel waiting for the line-store read data.
  dvt_ctl_t              s1_ctl;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [PIXEL_BITS-1:0] s1_left;

  // Stage two: registered contribution.
  dvt_ctl_t              s2_ctl;
  logic [CB-1:0]         s2_contrib;

  logic [PIXEL_BITS-1:0] up_even, up_odd;
  logic [ADDR_BITS-1:0]  lb_addr;

  logic [WCMP-1:0]    w_raw, w_max, w_eff, c_ext;
  logic [FH_BITS-1:0] h_eff, r_ext;
  logic               col_wrap, row_wrap, is_last_now;
  logic               adv, in_fire;
  dvt_ctl_t           s1_ctl_next;

  // --------------------------------------------------------------------------
  // Register writes: always ready; unknown indexes are dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= WIDTH_RESET;
      frame_height     <= HEIGHT_RESET;
      background_depth <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:      frame_width      <= FW_BITS'(cfg_data);
        REG_FRAME_HEIGHT:     frame_height     <= FH_BITS'(cfg_data);
        REG_BACKGROUND_DEPTH: background_depth <= BG_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Position decode for the pixel now on the input. Width and height are
  // clamped: zero acts as one, and oversize acts as the largest allowed.
  // --------------------------------------------------------------------------
  always_comb begin
    w_raw = WCMP'(frame_width);
    w_max = WCMP'(MAX_WIDTH);
    if (w_raw == '0) begin
      w_eff = WCMP'(1);
    end else if (w_raw > w_max) begin
      w_eff = w_max;
    end else begin
      w_eff = w_raw;
    end

    if (frame_height == '0) begin
      h_eff = FH_BITS'(1);
    end else if (frame_height > FH_BITS'(MAX_HEIGHT)) begin
      h_eff = FH_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end

    c_ext = WCMP'(column_count);
    r_ext = FH_BITS'(row_count);

    col_wrap    = (c_ext + WCMP'(1)) >= w_eff;
    row_wrap    = (r_ext + FH_BITS'(1)) >= h_eff;
    is_last_now = col_wrap && row_wrap;

    // Last column of an odd width, or last row of an odd height, stands alone.
    s1_ctl_next.valid     = 1'b1;
    s1_ctl_next.on_border = (w_eff[0] && (c_ext == w_eff - WCMP'(1))) ||
                            (h_eff[0] && (r_ext == h_eff - FH_BITS'(1)));
    s1_ctl_next.pair      = !s1_ctl_next.on_border && row_count[0] && column_count[0];
    s1_ctl_next.last      = is_last_now;
  end

  // Advance the whole pipe unless a frame end in the trim stage meets a volume
  // beat still held in the result register; then hold every stage and the
  // input until the receiver takes the beat.
  assign adv      = !(s2_ctl.valid && s2_ctl.last && out_valid && !out_ready);
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Raster counters, left pixel and stage-one registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
      s1_ctl       <= '0;
    end else begin
      if (adv) begin
        s1_ctl <= in_fire ? s1_ctl_next : '0;
      end
      if (in_fire) begin
        left_pixel <= depth_pixel;
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_count + ROW_BITS'(1);
        end else begin
          column_count <= column_count + COL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px   <= depth_pixel;
      s1_left <= left_pixel;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: even rows write, every beat reads the pair above. The read
  // data holds while no beat is taken, so a held stage one keeps its pair.
  // --------------------------------------------------------------------------
  assign lb_addr = ADDR_BITS'(column_count >> 1);

  dvt_line_buffer #(
    .PIXEL_BITS (PIXEL_BITS),
    .HALF_DEPTH (HALF_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_line_buffer (
    .clk     (clk),
    .wr_en   (in_fire && !row_count[0]),
    .wr_odd  (column_count[0]),
    .addr    (lb_addr),
    .wr_data (depth_pixel),
    .rd_en   (in_fire),
    .rd_even (up_even),
    .rd_odd  (up_odd)
  );

  // --------------------------------------------------------------------------
  // Trim stage and accumulator.
  // --------------------------------------------------------------------------
  dvt_trim_unit #(
    .PIXEL_BITS (PIXEL_BITS),
    .CB         (CB)
  ) u_trim (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (s1_ctl),
    .px      (s1_px),
    .left    (s1_left),
    .up_even (up_even),
    .up_odd  (up_odd),
    .bg      (background_depth),
    .ctl_out (s2_ctl),
    .contrib (s2_contrib)
  );

  dvt_accum #(
    .CB (CB)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ctl          (s2_ctl),
    .contrib      (s2_contrib),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .volume_total (volume_total)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A fresh result only ever follows a frame end leaving the trim stage.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_ctl.valid && s2_ctl.last))
    else $error("result raised without a frame end");

  // A volume beat not taken stays up with its value unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(volume_total)))
    else $error("held volume beat dropped or changed");

  // A pixel cannot be both a border pixel and the close of a 2x2 block.
  a_border_pair_excl: assert property (@(posedge clk) disable iff (rst)
    s1_ctl.valid |-> !(s1_ctl.on_border && s1_ctl.pair))
    else $error("border and block flags both set");

  // A frame end behind a held result waits in the trim stage.
  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (s2_ctl.valid && s2_ctl.last && out_valid && !out_ready) |=>
      (s2_ctl.valid && s2_ctl.last))
    else $error("frame end lost behind a held result");

endmodule

// ===== test/tb_depth_volume_trimmed_2x2.sv =====
// ----------------------------------------------------------------------------
// tb_depth_volume_trimmed_2x2
// Self-checking bench for the trimmed 2x2 depth volume block. A behavioural
// predictor follows every pixel beat and every register write. Each volume
// beat is compared with the oldest predicted frame volume. The stimulus is
// hand-picked corner frames, output back-pressure, clamped frame sizes and
// random frames, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_depth_volume_trimmed_2x2;
  timeunit 1ns;
  timeprecision 1ps;

  import dvt_pkg::*;

  // Index that no register decodes; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  localparam int                   ROW_STORE_DEPTH = DEF_MAX_WIDTH;
  localparam int                   COL_IDX_BITS    = $clog2(ROW_STORE_DEPTH);
  localparam longint unsigned      VOL_CAP         = (64'd1 << VOL_BITS) - 64'd1;
  localparam int                   SETTLE_CYCLES   = 6;    // drain time after the last volume beat
  localparam int                   HOLD_SPAN       = 400;  // long receiver hold-off
  localparam int                   QUIET_LIMIT     = 4000; // cycles with no beat at all
  localparam int                   TOTAL_PIXELS    = 1550; // pixel beats over the run

  typedef enum int {SINK_ALWAYS, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [DEF_PIXEL_BITS-1:0] depth_pixel;
  logic                     out_valid;
  logic                     out_ready;
  logic [VOL_BITS-1:0]      volume_total;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  depth_volume_trimmed_2x2 dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .depth_pixel  (depth_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .volume_total (volume_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the pixel pipeline
  // state, advanced on every accepted beat.
  // --------------------------------------------------------------------------
  logic [FW_BITS-1:0]        width_reg  = WIDTH_RESET;
  logic [FH_BITS-1:0]        height_reg = HEIGHT_RESET;
  logic [BG_BITS-1:0]        bg_reg     = BG_RESET;
  logic [DEF_PIXEL_BITS-1:0] upper_row [0:ROW_STORE_DEPTH-1];
  logic [DEF_PIXEL_BITS-1:0] left_px    = '0;
  logic [COL_IDX_BITS-1:0]   col_idx    = '0;
  logic [ROW_BITS-1:0]       row_idx    = '0;
  logic [VOL_BITS-1:0]       vol_acc    = '0;

  // Frame volumes predicted but not yet seen on the output, oldest first.
  logic [VOL_BITS-1:0] volumes_due [$];
  int                  mismatches  = 0;
  int                  pixels_sent = 0;

  // Stimulus controls shared between the test tasks and the receiver.
  bit         sender_gaps  = 1'b0;
  int         burst_left   = 0;
  sink_mode_t sink_mode    = SINK_ALWAYS;
  bit         hold_request = 1'b0;

  // A zero register acts as one; anything past the limit acts as the limit.
  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_STORE_DEPTH) return ROW_STORE_DEPTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  // Saturate the running volume at the top of its 40-bit range.
  function automatic void add_to_volume(input longint unsigned amount);
    longint unsigned acc;
    acc = 64'(vol_acc);
    if (amount > VOL_CAP - acc) vol_acc = VOL_CAP[VOL_BITS-1:0];
    else vol_acc = VOL_BITS'(acc + amount);
  endfunction

  // Fold one accepted pixel into the predicted volume. Returns 1 when the
  // pixel closes the frame, with the frame's volume in frame_vol.
  function automatic bit accumulate_pixel(input logic [DEF_PIXEL_BITS-1:0] px,
                                          output logic [VOL_BITS-1:0] frame_vol);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    int unsigned     r;
    longint unsigned bg;
    longint unsigned quad [4];
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned mid;
    bit              on_border;
    w = eff_width();
    h = eff_height();
    c = 32'(col_idx);
    r = 32'(row_idx);
    bg = 64'(bg_reg);
    frame_vol = '0;
    accumulate_pixel = 1'b0;

    // Odd last column and odd last row belong to no 2x2 block: plain excess.
    on_border = (w[0] && c == w - 1) || (h[0] && r == h - 1);
    if (on_border) begin
      if (64'(px) > bg) add_to_volume(64'(px) - bg);
    end else if (r[0] && c[0]) begin
      quad[0] = 64'(upper_row[COL_IDX_BITS'(c - 1)]);
      quad[1] = 64'(upper_row[COL_IDX_BITS'(c)]);
      quad[2] = 64'(left_px);
      quad[3] = 64'(px);
      hi = quad[0];
      lo = quad[0];
      for (int k = 1; k < 4; k++) begin
        if (quad[k] > hi) hi = quad[k];
        if (quad[k] < lo) lo = quad[k];
      end
      mid = quad[0] + quad[1] + quad[2] + quad[3] - hi - lo;
      if (2 * mid > 4 * bg) add_to_volume(2 * mid - 4 * bg);
    end

    if (!r[0] && c < ROW_STORE_DEPTH) upper_row[COL_IDX_BITS'(c)] = px;
    left_px = px;

    if (c + 1 >= w) begin
      col_idx = '0;
      if (r + 1 >= h) begin
        frame_vol = vol_acc;
        accumulate_pixel = 1'b1;
        vol_acc = '0;
        row_idx = '0;
      end else begin
        row_idx = ROW_BITS'(r + 1);
      end
    end else begin
      col_idx = COL_IDX_BITS'(c + 1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitor: sample everything at the rising edge, before the block's
  // own registers move. Check volume beats first, then apply register writes
  // and pixel beats to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [VOL_BITS-1:0] due;
    logic [VOL_BITS-1:0] frame_vol;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (volumes_due.size() == 0) begin
          $display("%0t ns: volume_total mismatch, expected no beat, got %0d",
                   $time, volume_total);
          mismatches++;
        end else begin
          due = volumes_due.pop_front();
          if (volume_total !== due) begin
            $display("%0t ns: volume_total mismatch, expected %0d, got %0d",
                     $time, due, volume_total);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      width_reg  = cfg_data[FW_BITS-1:0];
          REG_FRAME_HEIGHT:     height_reg = cfg_data[FH_BITS-1:0];
          REG_BACKGROUND_DEPTH: bg_reg     = cfg_data[BG_BITS-1:0];
          default: ;  // unmapped index: drop the write
        endcase
      end
      if (in_valid && in_ready) begin
        if (accumulate_pixel(depth_pixel, frame_vol)) volumes_due.push_back(frame_vol);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no beat of any kind moves for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Volume receiver: always ready, a rotating stall pattern, or random stalls.
  // A hold request keeps ready low for a fixed span counted here.
  // --------------------------------------------------------------------------
  initial begin : volume_sink
    logic [15:0] stall_pattern;
    stall_pattern = 16'b1101_0011_1011_0110;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_SPAN) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: out_ready <= 1'b1;
          SINK_PATTERN: begin
            out_ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
          end
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers. Every task starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one pixel and hold it until accepted. With gaps enabled, the sender
  // works in bursts of random length separated by random idle stretches.
  task automatic put_pixel(input logic [DEF_PIXEL_BITS-1:0] px);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    depth_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Write one register. Bits above the register's width carry random junk,
  // which the block must drop.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value,
                                input int reg_bits);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value | CFG_DATA_BITS'($urandom() << reg_bits);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame_geometry(input logic [CFG_DATA_BITS-1:0] width,
                                    input logic [CFG_DATA_BITS-1:0] height,
                                    input logic [CFG_DATA_BITS-1:0] background);
    write_register(REG_FRAME_WIDTH, width, FW_BITS);
    write_register(REG_FRAME_HEIGHT, height, FH_BITS);
    write_register(REG_BACKGROUND_DEPTH, background, BG_BITS);
  endtask

  // Stop offering pixels, wait for every predicted volume, then let the
  // pipeline run dry before anything touches the registers.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (volumes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly full-range values, some pinned to the extremes, many close to the
  // background so that the clipping at zero is exercised from both sides.
  function automatic logic [DEF_PIXEL_BITS-1:0] pick_depth();
    int near_bg;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        near_bg = int'(bg_reg) + int'($urandom_range(0, 600)) - 300;
        if (near_bg < 0) near_bg = 0;
        if (near_bg > 65535) near_bg = 65535;
        return DEF_PIXEL_BITS'(near_bg);
      end
      default: return DEF_PIXEL_BITS'($urandom());
    endcase
  endfunction

  task automatic send_random_frame();
    int unsigned count;
    count = eff_width() * eff_height();
    repeat (count) put_pixel(pick_depth());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Small hand-built frames: extremes of the pixel, ties, odd edges with the
  // shared corner, zero sizes, a background that swallows everything, and a
  // write to the unmapped index.
  task automatic test_directed_corners();
    sender_gaps = 1'b0;
    sink_mode   = SINK_ALWAYS;

    // Single block, extremes at both ends: the middle pair is 0 and full scale.
    set_frame_geometry(16'd2, 16'd2, 16'h0000);
    put_pixel(16'hFFFF);
    put_pixel(16'h0000);
    put_pixel(16'h0000);
    put_pixel(16'hFFFF);
    settle_idle();

    // 3x3: one block, odd last column and odd last row, corner counted once.
    // Pixels below the background add nothing.
    set_frame_geometry(16'd3, 16'd3, 16'h8000);
    put_pixel(16'hFFFF);
    put_pixel(16'h0000);
    put_pixel(16'h7FFF);
    put_pixel(16'h8001);
    put_pixel(16'hFFFF);
    put_pixel(16'h8000);
    put_pixel(16'hFFFF);
    put_pixel(16'h1234);
    put_pixel(16'hFFFF);
    settle_idle();

    // Zero width and zero height both act as one: a one-pixel frame.
    set_frame_geometry(16'd0, 16'd0, 16'h0000);
    put_pixel(16'hFFFF);
    settle_idle();

    // Background at full scale: every block clips to zero, ties included.
    set_frame_geometry(16'd2, 16'd2, 16'hFFFF);
    put_pixel(16'hFFFF);
    put_pixel(16'hFFFF);
    put_pixel(16'hFFFF);
    put_pixel(16'hFFFF);
    settle_idle();

    // Unmapped index with zero data: the background must stay at full scale.
    write_register(REG_UNMAPPED, 16'h0000, CFG_DATA_BITS);
    put_pixel(16'hFFFF);
    put_pixel(16'hFFFF);
    put_pixel(16'h8000);
    put_pixel(16'h8000);
    settle_idle();
  endtask

  // Hold the receiver off for a long stretch while tiny frames keep coming,
  // so the result register fills and the block stalls its input.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    sink_mode   = SINK_ALWAYS;
    set_frame_geometry(16'd2, 16'd2, 16'($urandom_range(0, 16'h8000)));
    hold_request = 1'b1;
    repeat (24) send_random_frame();
    settle_idle();

    // Again with random sender bursts and a stalling receiver.
    sender_gaps = 1'b1;
    sink_mode   = SINK_PATTERN;
    set_frame_geometry(16'd4, 16'd3, 16'($urandom()));
    hold_request = 1'b1;
    repeat (8) send_random_frame();
    settle_idle();
  endtask

  // Widest row: a width register past the limit clamps to the store depth.
  task automatic test_size_clamping();
    sender_gaps = 1'b1;
    sink_mode   = SINK_RANDOM;
    set_frame_geometry(16'hFFFF, 16'd1, 16'($urandom()));
    send_random_frame();
    settle_idle();
  endtask

  // Random geometry and background per phase, a few frames per phase, with
  // the idling style of both sides drawn afresh each time. Phases shrink
  // towards the end so the run lands close to its pixel budget.
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned remaining;
    int unsigned frame_px;
    int unsigned frames;
    logic [CFG_DATA_BITS-1:0] bg;
    while (pixels_sent < TOTAL_PIXELS) begin
      remaining = TOTAL_PIXELS - pixels_sent;
      case ($urandom_range(0, 9))
        0, 1:       w = $urandom_range(0, 3);
        2, 3, 4, 5, 6: w = $urandom_range(2, 12);
        7, 8:       w = $urandom_range(13, 48);
        default:    w = $urandom_range(49, 100);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    h = $urandom_range(0, 3);
        9:       h = $urandom_range(11, 24);
        default: h = $urandom_range(2, 10);
      endcase
      if (w > 48) h = $urandom_range(1, 2);
      if (w * h > remaining) h = 1;
      frame_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      frames = $urandom_range(1, 5);
      while (frames > 1 && frames * frame_px > remaining) frames--;
      case ($urandom_range(0, 3))
        0:       bg = '0;
        1:       bg = CFG_DATA_BITS'($urandom());
        default: bg = CFG_DATA_BITS'($urandom_range(16'h4000, 16'hC000));
      endcase
      sender_gaps = ($urandom_range(0, 2) != 0);
      sink_mode   = sink_mode_t'($urandom_range(0, 2));
      set_frame_geometry(CFG_DATA_BITS'(w), CFG_DATA_BITS'(h), bg);
      repeat (frames) send_random_frame();
      settle_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    depth_pixel = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_output_backpressure();
    test_size_clamping();
    test_random_frames();

    settle_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
